// ----- rtl/roman_numeral_encoder_macros.svh -----
// Assertion macros for the Roman numeral encoder checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ROMAN_NUMERAL_ENCODER_MACROS_SVH
`define ROMAN_NUMERAL_ENCODER_MACROS_SVH

// Same-cycle implication, masked during reset
`define RNE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset
`define RNE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rne_pkg.sv -----
// Shared constants, types and the greedy numeral table of the Roman numeral encoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rne_pkg;

  localparam int VALUE_W   = 16;
  localparam int REST_W    = 12;   // remainder of a value below 4000
  localparam int SYM_W     = 8;
  localparam int STATUS_W  = 2;
  localparam int TABLE_LEN = 13;
  localparam int IDX_W     = 4;

  typedef logic [REST_W-1:0]   rest_t;
  typedef logic [SYM_W-1:0]    sym_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [IDX_W-1:0]    idx_t;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_LOW  = 2'd1;
  localparam status_t ST_HIGH = 2'd2;

  localparam logic [VALUE_W-1:0] VALUE_LIMIT = 16'd4000;
  localparam sym_t SYM_NONE = 8'h00;

  localparam rest_t STEP_VALUE [TABLE_LEN] = '{
    12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
    12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
  };
  localparam sym_t STEP_FIRST [TABLE_LEN] = '{
    8'h4D, 8'h43, 8'h44, 8'h43, 8'h43, 8'h58, 8'h4C,
    8'h58, 8'h58, 8'h49, 8'h56, 8'h49, 8'h49
  };
  // second letter of a subtractive pair, SYM_NONE for a single letter
  localparam sym_t STEP_SECOND [TABLE_LEN] = '{
    SYM_NONE, 8'h4D, SYM_NONE, 8'h44, SYM_NONE, 8'h43, SYM_NONE,
    8'h4C, SYM_NONE, 8'h58, SYM_NONE, 8'h56, SYM_NONE
  };

  typedef struct packed {
    logic load;   // take the accepted value
    logic step;   // produce one result into the output register
  } rne_cmd_t;

  typedef struct packed {
    logic out_free;  // output register empty or being drained
    logic fin;       // result on offer is the last of the request
  } rne_sts_t;

endpackage

`default_nettype wire

// ----- rtl/rne_if.sv -----
// Valid/ready channel interfaces for the Roman numeral encoder.
// Depends on rne_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rne_in_if;
  import rne_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rne_out_if;
  import rne_pkg::*;
  logic       valid;
  logic       ready;
  sym_t       symbol;
  logic       has_symbol;
  status_t    status;
  logic       last;

  modport source (output valid, output symbol, output has_symbol, output status,
                  output last, input ready);
  modport sink   (input valid, input symbol, input has_symbol, input status,
                  input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/rne_datapath.sv -----
// Datapath: remainder, pending pair letter, greedy table search and output register.
// Depends on rne_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rne_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire rne_pkg::rne_cmd_t                 cmd,
  output rne_pkg::rne_sts_t                      sts,
  input  wire logic signed [rne_pkg::VALUE_W-1:0] in_value,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output rne_pkg::sym_t                          out_symbol,
  output logic                                   out_has_symbol,
  output rne_pkg::status_t                       out_status,
  output logic                                   out_last
);
  import rne_pkg::*;

  rest_t   rest_r, rest_nxt;
  status_t kind_r, kind_nxt;
  logic    pend_r, pend_nxt;
  sym_t    pend_sym_r, pend_sym_nxt;
  logic    out_valid_r, out_valid_nxt;
  sym_t    out_symbol_r;
  logic    out_has_r;
  status_t out_status_r;
  logic    out_last_r;

  idx_t    sel;
  rest_t   diff;
  logic    pair;
  sym_t    res_sym;
  logic    res_has;
  logic    res_last;

  // largest table entry not above the remainder
  always_comb begin
    sel = '0;
    for (int i = TABLE_LEN - 1; i >= 0; i--) begin
      if (rest_r >= STEP_VALUE[i]) begin
        sel = IDX_W'(i);
      end
    end
  end

  assign diff = rest_r - STEP_VALUE[sel];
  assign pair = (STEP_SECOND[sel] != SYM_NONE);

  always_comb begin
    rest_nxt     = rest_r;
    kind_nxt     = kind_r;
    pend_nxt     = pend_r;
    pend_sym_nxt = pend_sym_r;
    res_sym      = SYM_NONE;
    res_has      = 1'b0;
    res_last     = 1'b1;

    if (kind_r != ST_OK || (rest_r == '0 && !pend_r)) begin
      // error or zero: single empty result
    end else if (pend_r) begin
      res_sym  = pend_sym_r;
      res_has  = 1'b1;
      res_last = (rest_r == '0);
      if (cmd.step) begin
        pend_nxt = 1'b0;
      end
    end else begin
      res_sym  = STEP_FIRST[sel];
      res_has  = 1'b1;
      res_last = !pair && (diff == '0);
      if (cmd.step) begin
        rest_nxt     = diff;
        pend_nxt     = pair;
        pend_sym_nxt = STEP_SECOND[sel];
      end
    end

    if (cmd.load) begin
      pend_nxt = 1'b0;
      rest_nxt = in_value[REST_W-1:0];
      if (in_value[VALUE_W-1]) begin
        kind_nxt = ST_LOW;
      end else if ($unsigned(in_value) >= VALUE_LIMIT) begin
        kind_nxt = ST_HIGH;
      end else begin
        kind_nxt = ST_OK;
      end
    end
  end

  assign out_valid_nxt = cmd.step ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r     <= rest_nxt;
    kind_r     <= kind_nxt;
    pend_sym_r <= pend_sym_nxt;
    if (cmd.step) begin
      out_symbol_r <= res_sym;
      out_has_r    <= res_has;
      out_status_r <= kind_r;
      out_last_r   <= res_last;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.fin      = res_last;

  assign out_valid      = out_valid_r;
  assign out_symbol     = out_symbol_r;
  assign out_has_symbol = out_has_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/rne_ctrl.sv -----
// Controller: accepts one request, then steps the datapath once per result.
// Depends on rne_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rne_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rne_pkg::rne_sts_t sts,
  output rne_pkg::rne_cmd_t      cmd
);
  import rne_pkg::*;

  typedef enum logic {IDLE, RUN} state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  assign cmd.load = in_valid && in_ready_r;
  assign cmd.step = (state_r == RUN) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      IDLE: begin
        if (cmd.load) begin
          state_nxt = RUN;
        end
      end
      RUN: begin
        if (cmd.step && sts.fin) begin
          state_nxt = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

`default_nettype wire

// ----- rtl/roman_numeral_encoder.sv -----
// Roman numeral encoder: one request in, one ASCII letter per result out.
// A taken request moves the controller to RUN, which then steps the datapath.
// Throughput: a request gives 1..15 one-letter results; the next request is
//   taken after its last; one result per cycle while the output register is free.
// Reset: synchronous, active low; clears controller, output valid, pending flag.
// Depends on rne_pkg, rne_if, rne_ctrl and rne_datapath.
`timescale 1ns / 1ps
`default_nettype none

module roman_numeral_encoder (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rne_in_if.sink     in_ch,
  rne_out_if.source  out_ch
);
  import rne_pkg::*;

  rne_cmd_t cmd;
  rne_sts_t sts;

  // Controller: IDLE takes a request (ready is high only there), RUN issues one
  // step per cycle while the output register can take a result, and returns to
  // IDLE once the last-marked result has been produced.
  rne_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: each step finds the largest table entry that fits the remainder,
  // emits its first letter and subtracts; a subtractive pair leaves its second
  // letter pending for the next step. Error and zero requests give one empty
  // result. The output register decouples the consumer from the stepping.
  rne_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_value       (in_ch.value),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_symbol     (out_ch.symbol),
    .out_has_symbol (out_ch.has_symbol),
    .out_status     (out_ch.status),
    .out_last       (out_ch.last)
  );

endmodule

`default_nettype wire

// ----- rtl/rne_checker.sv -----
// Port-level checks for the Roman numeral encoder, bound to the top level.
// Depends on rne_pkg, rne_if and roman_numeral_encoder_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "roman_numeral_encoder_macros.svh"

module rne_checker (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rne_in_if.sink     in_ch,
  rne_out_if.source  out_ch
);
  import rne_pkg::*;

  // one request at a time: no back-to-back accept
  `RNE_ASSERT_NEXT(a_one_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready, "second request taken while busy")

  // stalled result holds
  `RNE_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.symbol) && $stable(out_ch.last), "stalled result changed")

  // error status only on a single empty result
  `RNE_ASSERT_NOW(a_err_single, out_ch.valid && out_ch.status != ST_OK, !out_ch.has_symbol && out_ch.last, "error result not single and empty")

  // an empty result always closes its request
  `RNE_ASSERT_NOW(a_empty_last, out_ch.valid && !out_ch.has_symbol, out_ch.last && out_ch.symbol == SYM_NONE, "empty result not last")

endmodule

bind roman_numeral_encoder rne_checker u_rne_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

`default_nettype wire
